FILE: hw/rtl/ptw_pkg.sv
// Shared types and constants for the page table walker.
// Depends on nothing; imported by page_table_walker.
`timescale 1ns / 1ps

package ptw_pkg;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // Input opcodes.
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_READ_DATA = 1'b1;

    // Table levels: the level of the entry being awaited.
    localparam logic [1:0] LVL_TOP  = 2'd3;
    localparam logic [1:0] LVL_PTR  = 2'd2;
    localparam logic [1:0] LVL_DIR  = 2'd1;
    localparam logic [1:0] LVL_LEAF = 2'd0;

    // Entry flag bit positions.
    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    localparam int VA_W   = 48;
    localparam int ROOT_W = 40;
    localparam int WORD_W = 64;
    localparam int IDX_W  = 9;

    typedef struct packed {
        logic              opcode;
        logic [VA_W-1:0]   virt_addr;
        logic [WORD_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] address;
        logic              found;
    } t_out_item;

endpackage

FILE: hw/rtl/page_table_walker.sv
// Throughput: one item per cycle while the output stage has room; each item is
// handled in a single registered pass, its result written to the result or skid register.
// A two-entry output stage (result register plus skid register) lets an item be
// accepted while an earlier result still waits; input ready drops only when both are full.
// Reset (synchronous, active low) leaves the walker idle, root frame zero, output empty.
// Top level of the four-level page table walker; depends on ptw_pkg.
`timescale 1ns / 1ps

module page_table_walker
    import ptw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write channel: root frame number.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ROOT_W-1:0]   i_cfg_data,
    // Input item channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in,
    // Result item channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out
);

    // Walk state. The walk is advanced at the moment an item is accepted, so the
    // next item always sees the state that the previous one left behind.
    logic [ROOT_W-1:0] r_root_frame;
    logic              r_busy,       n_busy;
    logic [1:0]        r_walk_level, n_walk_level;
    logic [VA_W-1:0]   r_saved_virt, n_saved_virt;

    // Output stage: the result register and a skid register behind it.
    t_out_item r_out,  r_skid;
    logic      r_out_valid, r_skid_valid;
    t_out_item n_res;

    logic in_fire, out_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;

    // Table index of a virtual address at a given level: bits 12+9*level upwards.
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_TOP:  idx = va[47:39];
            LVL_PTR:  idx = va[38:30];
            LVL_DIR:  idx = va[29:21];
            LVL_LEAF: idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

    // One step of the walk. Every address is a concatenation: the index times
    // eight never reaches bit 12 and the page offset never reaches the cleared
    // bits of the entry, so no adder is needed.
    always_comb begin
        logic [1:0] lower;
        lower        = r_walk_level - 2'd1;
        n_busy       = r_busy;
        n_walk_level = r_walk_level;
        n_saved_virt = r_saved_virt;
        n_res.kind    = KIND_REJECT;
        n_res.address = '0;
        n_res.found   = 1'b0;

        if (i_in.opcode == OP_TRANSLATE) begin
            if (!r_busy) begin
                // Start a walk at the top-level table.
                n_busy        = 1'b1;
                n_walk_level  = LVL_TOP;
                n_saved_virt  = i_in.virt_addr;
                n_res.kind    = KIND_READ;
                n_res.address = {{(WORD_W-ROOT_W-12){1'b0}}, r_root_frame,
                                 level_index(i_in.virt_addr, LVL_TOP), 3'b000};
            end
        end else if (r_busy) begin
            if (!i_in.read_data[BIT_PRESENT]) begin
                // Entry not present: the address is unmapped.
                n_busy       = 1'b0;
                n_walk_level = LVL_LEAF;
                n_res.kind   = KIND_DONE;
            end else if (r_walk_level == LVL_DIR && i_in.read_data[BIT_LARGE]) begin
                // Large page at directory level: 2 MiB frame.
                n_busy        = 1'b0;
                n_walk_level  = LVL_LEAF;
                n_res.kind    = KIND_DONE;
                n_res.address = {i_in.read_data[WORD_W-1:21], r_saved_virt[20:0]};
                n_res.found   = 1'b1;
            end else if (r_walk_level == LVL_LEAF) begin
                // Leaf entry: 4 KiB frame.
                n_busy        = 1'b0;
                n_res.kind    = KIND_DONE;
                n_res.address = {i_in.read_data[WORD_W-1:12], r_saved_virt[11:0]};
                n_res.found   = 1'b1;
            end else begin
                // Descend one level; the large-page bit is ignored above the directory.
                n_walk_level  = lower;
                n_res.kind    = KIND_READ;
                n_res.address = {i_in.read_data[WORD_W-1:12],
                                 level_index(r_saved_virt, lower), 3'b000};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_frame <= '0;
            r_busy       <= 1'b0;
            r_walk_level <= LVL_LEAF;
            r_saved_virt <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_root_frame <= i_cfg_data;
            end
            if (in_fire) begin
                r_busy       <= n_busy;
                r_walk_level <= n_walk_level;
                r_saved_virt <= n_saved_virt;
            end

            // Output stage. While the skid register is full no item is accepted,
            // so its content moves forward as soon as the result is taken.
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (!r_out_valid || out_fire) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_res;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The skid register is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the result register is empty");

    // A translate request taken while idle starts a walk at the top level.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.opcode == OP_TRANSLATE && !r_busy)
        |=> (r_busy && r_walk_level == LVL_TOP))
        else $error("translate request did not start a walk at the top level");

    // An entry without the present bit ends the walk.
    a_not_present_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.opcode == OP_READ_DATA && r_busy && !i_in.read_data[BIT_PRESENT])
        |=> !r_busy)
        else $error("walk continued after an entry without the present bit");

    // A rejected result never carries an address or a found flag.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_REJECT) |-> (r_out.address == '0 && !r_out.found))
        else $error("rejected result carries an address or found flag");
`endif

endmodule
